// ===== design/hcbd_pkg.sv =====
// Types and constants shared by the chunked body decoder modules.
`default_nettype none
package hcbd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } body_beat_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [2:0] decode_status;
        logic       finished;
    } result_beat_t;

    typedef enum logic [2:0] {
        CLS_HEX,
        CLS_SEMI,
        CLS_CR,
        CLS_LF,
        CLS_WS,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        eoi;
        char_class_t cls;
        logic [3:0]  hex_val;
    } token_t;

    typedef enum logic [3:0] {
        PH_LEAD,
        PH_HEX,
        PH_TRAIL,
        PH_EXT,
        PH_LINE_CR,
        PH_EXT_CR,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_OK,
        ST_NOLINE,
        ST_EMPTY,
        ST_BADHEX,
        ST_SHORT,
        ST_NODATA
    } status_t;

endpackage
`default_nettype wire

// ===== design/hcbd_classifier.sv =====
// Front end: classifies each accepted body byte into a token for the queue.
`default_nettype none
module hcbd_classifier (
    input  hcbd_pkg::body_beat_t beat,
    output hcbd_pkg::token_t     token
);

    always_comb
    begin
        token.data_byte = beat.data_byte;
        token.eoi       = beat.end_of_input;
        token.hex_val   = 4'd0;
        if (beat.data_byte >= 8'h30 && beat.data_byte <= 8'h39)
        begin
            token.cls     = hcbd_pkg::CLS_HEX;
            token.hex_val = 4'(beat.data_byte - 8'h30);
        end
        else if (beat.data_byte >= 8'h61 && beat.data_byte <= 8'h66)
        begin
            token.cls     = hcbd_pkg::CLS_HEX;
            token.hex_val = 4'(beat.data_byte - 8'h57);
        end
        else if (beat.data_byte >= 8'h41 && beat.data_byte <= 8'h46)
        begin
            token.cls     = hcbd_pkg::CLS_HEX;
            token.hex_val = 4'(beat.data_byte - 8'h37);
        end
        else if (beat.data_byte == hcbd_pkg::CHAR_SEMI)
        begin
            token.cls = hcbd_pkg::CLS_SEMI;
        end
        else if (beat.data_byte == hcbd_pkg::CHAR_CR)
        begin
            token.cls = hcbd_pkg::CLS_CR;
        end
        else if (beat.data_byte == hcbd_pkg::CHAR_LF)
        begin
            token.cls = hcbd_pkg::CLS_LF;
        end
        else if (beat.data_byte == hcbd_pkg::CHAR_SP || beat.data_byte == hcbd_pkg::CHAR_TAB)
        begin
            token.cls = hcbd_pkg::CLS_WS;
        end
        else
        begin
            token.cls = hcbd_pkg::CLS_OTHER;
        end
    end

endmodule
`default_nettype wire

// ===== design/hcbd_queue.sv =====
// Short token queue between the classifier and the framing engine.
`default_nettype none
module hcbd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hcbd_pkg::token_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output hcbd_pkg::token_t pop_data
);

    hcbd_pkg::token_t                   mem [hcbd_pkg::QUEUE_DEPTH];
    logic [hcbd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [hcbd_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [hcbd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [hcbd_pkg::QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [hcbd_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [hcbd_pkg::QUEUE_CNT_W-1:0]   count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full      = (count_reg == hcbd_pkg::QUEUE_CNT_W'(hcbd_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + hcbd_pkg::QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + hcbd_pkg::QUEUE_PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + hcbd_pkg::QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - hcbd_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== design/hcbd_framer.sv =====
// Back end: chunk framing state machine with a registered result stage.
`default_nettype none
module hcbd_framer #(
    parameter int SIZE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   tok_valid,
    input  hcbd_pkg::token_t       tok,
    output logic                   tok_pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output hcbd_pkg::result_beat_t result
);

    hcbd_pkg::phase_t       phase_reg;
    hcbd_pkg::phase_t       phase_next;
    hcbd_pkg::phase_t       pre_phase;
    hcbd_pkg::status_t      status_reg;
    hcbd_pkg::status_t      status_next;
    logic [SIZE_BITS-1:0]   counter_reg;
    logic [SIZE_BITS-1:0]   counter_next;
    logic                   digit_reg;
    logic                   digit_next;
    logic                   bad_reg;
    logic                   bad_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    hcbd_pkg::result_beat_t out_reg;
    hcbd_pkg::result_beat_t out_next;

    assign tok_pop      = tok_valid && (!out_valid_reg || result_ready);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign pre_phase    = (phase_reg == hcbd_pkg::PH_LINE_CR) ? hcbd_pkg::PH_TRAIL : phase_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        status_next  = status_reg;
        counter_next = counter_reg;
        digit_next   = digit_reg;
        bad_next     = bad_reg;
        if (tok_pop && phase_reg != hcbd_pkg::PH_DONE)
        begin
            if (tok.eoi)
            begin
                phase_next = hcbd_pkg::PH_DONE;
                case (phase_reg)
                    hcbd_pkg::PH_DATA:    status_next = hcbd_pkg::ST_SHORT;
                    hcbd_pkg::PH_DATA_CR: status_next = hcbd_pkg::ST_NODATA;
                    hcbd_pkg::PH_DATA_LF: status_next = hcbd_pkg::ST_NODATA;
                    default:              status_next = hcbd_pkg::ST_NOLINE;
                endcase
            end
            else
            begin
                case (phase_reg)
                    hcbd_pkg::PH_LEAD, hcbd_pkg::PH_HEX, hcbd_pkg::PH_TRAIL,
                    hcbd_pkg::PH_LINE_CR:
                    begin
                        if (phase_reg == hcbd_pkg::PH_LINE_CR && tok.cls == hcbd_pkg::CLS_LF)
                        begin
                            if (bad_reg)
                            begin
                                status_next = hcbd_pkg::ST_BADHEX;
                                phase_next  = hcbd_pkg::PH_DONE;
                            end
                            else if (!digit_reg)
                            begin
                                status_next = hcbd_pkg::ST_EMPTY;
                                phase_next  = hcbd_pkg::PH_DONE;
                            end
                            else if (counter_reg == '0)
                            begin
                                status_next = hcbd_pkg::ST_OK;
                                phase_next  = hcbd_pkg::PH_DONE;
                            end
                            else
                            begin
                                phase_next = hcbd_pkg::PH_DATA;
                            end
                        end
                        else if (phase_reg == hcbd_pkg::PH_LINE_CR
                                 && tok.cls == hcbd_pkg::CLS_CR)
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            if (phase_reg == hcbd_pkg::PH_LINE_CR)
                            begin
                                bad_next = 1'b1;
                            end
                            case (tok.cls)
                                hcbd_pkg::CLS_SEMI:
                                begin
                                    phase_next = hcbd_pkg::PH_EXT;
                                end
                                hcbd_pkg::CLS_CR:
                                begin
                                    phase_next = hcbd_pkg::PH_LINE_CR;
                                end
                                hcbd_pkg::CLS_WS:
                                begin
                                    phase_next = (pre_phase == hcbd_pkg::PH_HEX)
                                                 ? hcbd_pkg::PH_TRAIL : pre_phase;
                                end
                                hcbd_pkg::CLS_HEX:
                                begin
                                    if (pre_phase == hcbd_pkg::PH_LEAD
                                        || pre_phase == hcbd_pkg::PH_HEX)
                                    begin
                                        if (counter_reg[SIZE_BITS-1:SIZE_BITS-4] != 4'd0)
                                        begin
                                            bad_next = 1'b1;
                                        end
                                        counter_next = {counter_reg[SIZE_BITS-5:0], tok.hex_val};
                                        digit_next   = 1'b1;
                                        phase_next   = hcbd_pkg::PH_HEX;
                                    end
                                    else
                                    begin
                                        bad_next   = 1'b1;
                                        phase_next = hcbd_pkg::PH_TRAIL;
                                    end
                                end
                                default:
                                begin
                                    bad_next   = 1'b1;
                                    phase_next = hcbd_pkg::PH_TRAIL;
                                end
                            endcase
                        end
                    end
                    hcbd_pkg::PH_EXT:
                    begin
                        if (tok.cls == hcbd_pkg::CLS_CR)
                        begin
                            phase_next = hcbd_pkg::PH_EXT_CR;
                        end
                    end
                    hcbd_pkg::PH_EXT_CR:
                    begin
                        if (tok.cls == hcbd_pkg::CLS_LF)
                        begin
                            if (bad_reg)
                            begin
                                status_next = hcbd_pkg::ST_BADHEX;
                                phase_next  = hcbd_pkg::PH_DONE;
                            end
                            else if (!digit_reg)
                            begin
                                status_next = hcbd_pkg::ST_EMPTY;
                                phase_next  = hcbd_pkg::PH_DONE;
                            end
                            else if (counter_reg == '0)
                            begin
                                status_next = hcbd_pkg::ST_OK;
                                phase_next  = hcbd_pkg::PH_DONE;
                            end
                            else
                            begin
                                phase_next = hcbd_pkg::PH_DATA;
                            end
                        end
                        else if (tok.cls != hcbd_pkg::CLS_CR)
                        begin
                            phase_next = hcbd_pkg::PH_EXT;
                        end
                    end
                    hcbd_pkg::PH_DATA:
                    begin
                        counter_next = counter_reg - SIZE_BITS'(1);
                        if (counter_reg == SIZE_BITS'(1))
                        begin
                            phase_next = hcbd_pkg::PH_DATA_CR;
                        end
                    end
                    hcbd_pkg::PH_DATA_CR:
                    begin
                        if (tok.cls == hcbd_pkg::CLS_CR)
                        begin
                            phase_next = hcbd_pkg::PH_DATA_LF;
                        end
                        else
                        begin
                            status_next = hcbd_pkg::ST_NODATA;
                            phase_next  = hcbd_pkg::PH_DONE;
                        end
                    end
                    hcbd_pkg::PH_DATA_LF:
                    begin
                        if (tok.cls == hcbd_pkg::CLS_LF)
                        begin
                            phase_next   = hcbd_pkg::PH_LEAD;
                            counter_next = '0;
                            digit_next   = 1'b0;
                            bad_next     = 1'b0;
                        end
                        else
                        begin
                            status_next = hcbd_pkg::ST_NODATA;
                            phase_next  = hcbd_pkg::PH_DONE;
                        end
                    end
                    default:
                    begin
                        status_next = hcbd_pkg::ST_BADHEX;
                        phase_next  = hcbd_pkg::PH_DONE;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        out_next.payload_valid = tok_pop && !tok.eoi && (phase_reg == hcbd_pkg::PH_DATA);
        out_next.payload_byte  = out_next.payload_valid ? tok.data_byte : 8'd0;
        out_next.decode_status = status_next;
        out_next.finished      = (phase_next == hcbd_pkg::PH_DONE);
        if (tok_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hcbd_pkg::PH_LEAD;
            status_reg    <= hcbd_pkg::ST_RUN;
            counter_reg   <= '0;
            digit_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            status_reg    <= status_next;
            counter_reg   <= counter_next;
            digit_reg     <= digit_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop)
        begin
            out_reg <= out_next;
        end
    end

    a_done_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hcbd_pkg::PH_DONE |=> phase_reg == hcbd_pkg::PH_DONE)
        else $error("framer left the done phase");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hcbd_pkg::PH_DATA |-> counter_reg != '0)
        else $error("data phase with zero bytes due");

    a_finished_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.finished |-> out_reg.decode_status != hcbd_pkg::ST_RUN)
        else $error("finished beat reports running status");

    a_payload_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.payload_valid |-> !out_reg.finished)
        else $error("payload beat marked finished");

endmodule
`default_nettype wire

// ===== design/http_chunked_body_decoder_top.sv =====
// Top level of the HTTP/1.1 chunked transfer body decoder.
// Path: a body beat is written into the token queue, then registered in the result stage.
// Throughput: one body beat per cycle unless result_ready back-pressure fills the queue.
// A four-entry token queue parts the classifier from the framing engine.
// Reset (rst_n low, asynchronous) empties the queue and the result stage
// and returns the framer to the start of a size line with running status.
`default_nettype none
module http_chunked_body_decoder_top #(
    parameter int SIZE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   body_valid,
    output logic                   body_ready,
    input  hcbd_pkg::body_beat_t   body,
    output logic                   result_valid,
    input  logic                   result_ready,
    output hcbd_pkg::result_beat_t result
);

    hcbd_pkg::token_t in_token;
    hcbd_pkg::token_t q_token;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;

    assign body_ready = !q_full;

    hcbd_classifier u_classifier (
        .beat  (body),
        .token (in_token)
    );

    hcbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (body_valid),
        .push_data (in_token),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_token)
    );

    hcbd_framer #(
        .SIZE_BITS (SIZE_BITS)
    ) u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (q_not_empty),
        .tok          (q_token),
        .tok_pop      (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire
